// ===== sv/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg
// shared types and constants for the breaker coil sequencer
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int unsigned DelayW   = 12;
  localparam int unsigned OnPulseW = 8;
  localparam int unsigned FgW      = 10;
  localparam int unsigned PulseW   = 11;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_ON    = 2'd2,
    MODE_TRIP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_RESET = 3'd1,
    CMD_OFF   = 3'd2,
    CMD_ON    = 3'd3,
    CMD_TRIP  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_RESET = 3'd1,
    EV_OFF   = 3'd2,
    EV_ON    = 3'd3,
    EV_TRIP  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    REG_BREAKER_TYPE = 3'd0,
    REG_HAS_UVR      = 3'd1,
    REG_HAS_FEEDBACK = 3'd2,
    REG_RESET_DELAY  = 3'd3,
    REG_ON_PULSE     = 3'd4,
    REG_FG_ON        = 3'd5,
    REG_START_ON     = 3'd6
  } reg_addr_t;

  typedef struct packed {
    logic                breaker_type;
    logic                has_uvr;
    logic                has_feedback;
    logic [DelayW-1:0]   reset_delay_ticks;
    logic [OnPulseW-1:0] on_pulse_ticks;
    logic [FgW-1:0]      fg_on_ticks;
    logic                start_on;
  } cfg_t;

  // start_on write, used to preset the mode before the first word
  typedef struct packed {
    logic wr;
    logic value;
  } preset_t;

  typedef struct packed {
    mode_t  state;
    logic   on_coil;
    logic   off_coil;
    logic   uvr_coil;
    logic   fault;
    event_t ev;
  } result_t;

endpackage

// ===== sv/bcs_regs.sv =====
// ----------------------------------------------------------------------------
// bcs_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module bcs_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcs_pkg::AddrW-1:0]     paddr,
  input  logic [bcs_pkg::DataW-1:0]     pwdata,
  output logic [bcs_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  output bcs_pkg::cfg_t                 cfg,
  output bcs_pkg::preset_t              preset
);

  bcs_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_nxt      = cfg_r;
    preset.wr    = 1'b0;
    preset.value = pwdata[0];
    if (wr_en) begin
      unique case (idx)
        bcs_pkg::REG_BREAKER_TYPE: cfg_nxt.breaker_type = pwdata[0];
        bcs_pkg::REG_HAS_UVR:      cfg_nxt.has_uvr = pwdata[0];
        bcs_pkg::REG_HAS_FEEDBACK: cfg_nxt.has_feedback = pwdata[0];
        bcs_pkg::REG_RESET_DELAY:
          cfg_nxt.reset_delay_ticks = pwdata[bcs_pkg::DelayW-1:0];
        bcs_pkg::REG_ON_PULSE:
          cfg_nxt.on_pulse_ticks = pwdata[bcs_pkg::OnPulseW-1:0];
        bcs_pkg::REG_FG_ON:        cfg_nxt.fg_on_ticks = pwdata[bcs_pkg::FgW-1:0];
        bcs_pkg::REG_START_ON: begin
          cfg_nxt.start_on = pwdata[0];
          preset.wr        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.breaker_type      <= 1'b0;
      cfg_r.has_uvr           <= 1'b0;
      cfg_r.has_feedback      <= 1'b1;
      cfg_r.reset_delay_ticks <= 12'd1000;
      cfg_r.on_pulse_ticks    <= 8'd10;
      cfg_r.fg_on_ticks       <= 10'd120;
      cfg_r.start_on          <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      bcs_pkg::REG_BREAKER_TYPE: prdata[0] = cfg_r.breaker_type;
      bcs_pkg::REG_HAS_UVR:      prdata[0] = cfg_r.has_uvr;
      bcs_pkg::REG_HAS_FEEDBACK: prdata[0] = cfg_r.has_feedback;
      bcs_pkg::REG_RESET_DELAY:
        prdata[bcs_pkg::DelayW-1:0] = cfg_r.reset_delay_ticks;
      bcs_pkg::REG_ON_PULSE:
        prdata[bcs_pkg::OnPulseW-1:0] = cfg_r.on_pulse_ticks;
      bcs_pkg::REG_FG_ON:        prdata[bcs_pkg::FgW-1:0] = cfg_r.fg_on_ticks;
      bcs_pkg::REG_START_ON:     prdata[0] = cfg_r.start_on;
      default: ;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/bcs_core.sv =====
// ----------------------------------------------------------------------------
// bcs_core
// sequencer state, timers and coil drives; one word per step
// ----------------------------------------------------------------------------
module bcs_core #(
  parameter int PULSE_HIGH_TICKS   = 600,
  parameter int PULSE_PERIOD_TICKS = 1200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [2:0]        command,
  input  logic              feedback_closed,
  input  logic              inverter_running,
  input  bcs_pkg::cfg_t     cfg,
  input  bcs_pkg::preset_t  preset,
  output bcs_pkg::result_t  res
);

  localparam logic [bcs_pkg::PulseW-1:0] PulseHigh   =
    bcs_pkg::PulseW'(PULSE_HIGH_TICKS);
  localparam logic [bcs_pkg::PulseW-1:0] PulsePeriod =
    bcs_pkg::PulseW'(PULSE_PERIOD_TICKS);

  bcs_pkg::mode_t                mode_r, mode_nxt;
  logic [bcs_pkg::DelayW-1:0]    rst_tmr_r, rst_tmr_nxt;
  logic [bcs_pkg::OnPulseW-1:0]  on_tmr_r, on_tmr_nxt;
  logic [bcs_pkg::FgW-1:0]       fg_tmr_r, fg_tmr_nxt;
  logic [bcs_pkg::PulseW-1:0]    pulse_r, pulse_nxt;
  logic                          on_r, on_nxt;
  logic                          off_r, off_nxt;
  logic                          uvr_r, uvr_nxt;
  logic                          fresh_r;

  logic                          closed, shunt, go, fault;
  bcs_pkg::mode_t                target;
  bcs_pkg::event_t               ev;
  logic [bcs_pkg::DelayW-1:0]    rst_inc;
  logic [bcs_pkg::OnPulseW-1:0]  on_inc;
  logic [bcs_pkg::FgW-1:0]       fg_inc;
  logic [bcs_pkg::PulseW-1:0]    pulse_inc;

  assign closed = cfg.has_feedback && feedback_closed;
  assign shunt  = cfg.breaker_type;

  // saturating timers, finished once the count reaches the limit
  assign rst_inc   = (rst_tmr_r < cfg.reset_delay_ticks) ? rst_tmr_r + 1'b1 : rst_tmr_r;
  assign on_inc    = (on_tmr_r < cfg.on_pulse_ticks) ? on_tmr_r + 1'b1 : on_tmr_r;
  assign fg_inc    = (fg_tmr_r < cfg.fg_on_ticks) ? fg_tmr_r + 1'b1 : fg_tmr_r;
  assign pulse_inc = pulse_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    rst_tmr_nxt = rst_tmr_r;
    on_tmr_nxt  = on_tmr_r;
    fg_tmr_nxt  = fg_tmr_r;
    pulse_nxt   = pulse_r;
    on_nxt      = on_r;
    off_nxt     = off_r;
    uvr_nxt     = uvr_r;
    ev          = bcs_pkg::EV_NONE;
    fault       = 1'b0;
    go          = 1'b0;
    target      = bcs_pkg::MODE_RESET;

    case (command)
      bcs_pkg::CMD_TICK: begin
        unique case (mode_r)
          bcs_pkg::MODE_RESET: begin
            on_nxt = 1'b0;
            if (!shunt) off_nxt = 1'b1;
            if (cfg.has_uvr) uvr_nxt = !shunt;
            rst_tmr_nxt = rst_inc;
            if (rst_inc >= cfg.reset_delay_ticks) begin
              if (closed) begin
                fault = 1'b1;
              end else begin
                mode_nxt = bcs_pkg::MODE_OFF;
                off_nxt  = 1'b0;
                ev       = bcs_pkg::EV_OFF;
              end
            end
          end
          bcs_pkg::MODE_OFF: begin
            // periodic reset pulse on the off coil while open and idle
            if (!closed && !shunt) begin
              if (!inverter_running) begin
                off_nxt   = pulse_inc < PulseHigh;
                pulse_nxt = (pulse_inc > PulsePeriod) ? '0 : pulse_inc;
              end else begin
                off_nxt = 1'b0;
              end
            end
          end
          bcs_pkg::MODE_ON: begin
            if (shunt) begin
              fg_tmr_nxt = fg_inc;
              if (fg_inc >= cfg.fg_on_ticks) off_nxt = 1'b0;
            end else begin
              on_tmr_nxt = on_inc;
              if (on_inc >= cfg.on_pulse_ticks) begin
                on_nxt  = 1'b1;
                off_nxt = 1'b0;
              end
              if (closed) on_nxt = 1'b0;
            end
          end
          bcs_pkg::MODE_TRIP: ;
          default: ;
        endcase
      end
      bcs_pkg::CMD_RESET: begin
        go     = mode_r == bcs_pkg::MODE_TRIP;
        target = bcs_pkg::MODE_RESET;
      end
      bcs_pkg::CMD_OFF: begin
        go     = mode_r == bcs_pkg::MODE_ON;
        target = bcs_pkg::MODE_OFF;
      end
      bcs_pkg::CMD_ON: begin
        go     = mode_r == bcs_pkg::MODE_OFF;
        target = bcs_pkg::MODE_ON;
      end
      bcs_pkg::CMD_TRIP: begin
        go     = mode_r != bcs_pkg::MODE_TRIP;
        target = bcs_pkg::MODE_TRIP;
      end
      default: ;
    endcase

    if (go) begin
      fg_tmr_nxt = '0;
      unique case (target)
        bcs_pkg::MODE_RESET: begin
          mode_nxt    = bcs_pkg::MODE_RESET;
          rst_tmr_nxt = '0;
          ev          = bcs_pkg::EV_RESET;
        end
        bcs_pkg::MODE_OFF: begin
          mode_nxt  = bcs_pkg::MODE_OFF;
          pulse_nxt = '0;
          on_nxt    = 1'b0;
          off_nxt   = !shunt;
          ev        = bcs_pkg::EV_OFF;
        end
        bcs_pkg::MODE_ON: begin
          mode_nxt   = bcs_pkg::MODE_ON;
          on_tmr_nxt = '0;
          on_nxt     = shunt;
          off_nxt    = shunt;
          ev         = bcs_pkg::EV_ON;
        end
        bcs_pkg::MODE_TRIP: begin
          on_nxt = 1'b0;
          // no undervoltage release: trip falls back to off
          if (!cfg.has_uvr) begin
            mode_nxt = bcs_pkg::MODE_OFF;
            off_nxt  = 1'b1;
            ev       = bcs_pkg::EV_OFF;
          end else begin
            mode_nxt = bcs_pkg::MODE_TRIP;
            uvr_nxt  = shunt;
            off_nxt  = 1'b0;
            ev       = bcs_pkg::EV_TRIP;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bcs_pkg::MODE_RESET;
      rst_tmr_r <= '0;
      on_tmr_r  <= '0;
      fg_tmr_r  <= '0;
      pulse_r   <= '0;
      on_r      <= 1'b0;
      off_r     <= 1'b0;
      uvr_r     <= 1'b0;
      fresh_r   <= 1'b1;
    end else if (step) begin
      mode_r    <= mode_nxt;
      rst_tmr_r <= rst_tmr_nxt;
      on_tmr_r  <= on_tmr_nxt;
      fg_tmr_r  <= fg_tmr_nxt;
      pulse_r   <= pulse_nxt;
      on_r      <= on_nxt;
      off_r     <= off_nxt;
      uvr_r     <= uvr_nxt;
      fresh_r   <= 1'b0;
    end else if (preset.wr && fresh_r) begin
      mode_r <= preset.value ? bcs_pkg::MODE_ON : bcs_pkg::MODE_RESET;
    end
  end

  assign res.state    = mode_nxt;
  assign res.on_coil  = on_nxt;
  assign res.off_coil = off_nxt;
  assign res.uvr_coil = uvr_nxt;
  assign res.fault    = fault;
  assign res.ev       = ev;

  a_fault_in_reset: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.fault |-> res.state == bcs_pkg::MODE_RESET && res.ev == bcs_pkg::EV_NONE)
    else $error("fault raised outside the reset wait");

  a_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.ev == bcs_pkg::EV_ON |-> res.state == bcs_pkg::MODE_ON)
    else $error("on event without entering on");

  a_trip_coils: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.ev == bcs_pkg::EV_TRIP |->
      res.state == bcs_pkg::MODE_TRIP && !res.on_coil && !res.off_coil)
    else $error("trip left a coil closed");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r <= PulsePeriod)
    else $error("reset pulse counter beyond its period");

endmodule

// ===== sv/breaker_coil_sequencer.sv =====
// ----------------------------------------------------------------------------
// breaker_coil_sequencer
// coil sequencer for a breaker or contactor: reset, off, on and trip modes
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid/in_ready    command, feedback_closed, inverter_running
//  out      out_valid/out_ready  breaker_state, coils, fault, event_code
//  cfg      psel/penable/pwrite  paddr (reg i at 4*i), pwdata, prdata
//
//  one word per cycle sustained while results are taken; each word passes
//  through the input register and leaves through the result register
//  the sequencer state is updated as the word moves into the result register
//  a stalled result holds the result register; the input register still
//  takes one more word, then in_ready drops until the result is taken
//  synchronous active-low reset clears the pipeline, mode, timers and coils
//
module breaker_coil_sequencer #(
  parameter int PULSE_HIGH_TICKS   = 600,
  parameter int PULSE_PERIOD_TICKS = 1200
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_command,
  input  logic                       in_feedback_closed,
  input  logic                       in_inverter_running,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_breaker_state,
  output logic                       out_on_coil,
  output logic                       out_off_coil,
  output logic                       out_uvr_coil,
  output logic                       out_fault,
  output logic [2:0]                 out_event_code,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bcs_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [bcs_pkg::DataW-1:0]  cfg_pwdata,
  output logic [bcs_pkg::DataW-1:0]  cfg_prdata,
  output logic                       cfg_pready
);

  bcs_pkg::cfg_t     cfg;
  bcs_pkg::preset_t  preset;
  bcs_pkg::result_t  res;

  // input register
  logic              s1_v_r, s1_v_nxt;
  logic [2:0]        s1_cmd_r;
  logic              s1_fb_r;
  logic              s1_run_r;

  // result register
  logic              out_v_r, out_v_nxt;
  bcs_pkg::result_t  out_r;

  logic              in_acc;
  logic              adv;
  logic              step;

  // result register free, or emptying this cycle
  assign adv      = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign step     = s1_v_r && adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) s1_v_nxt = 1'b1;
    else if (adv) s1_v_nxt = 1'b0;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (step) out_v_nxt = 1'b1;
    else if (out_ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_command;
      s1_fb_r  <= in_feedback_closed;
      s1_run_r <= in_inverter_running;
    end
    if (step) out_r <= res;
  end

  bcs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .preset  (preset)
  );

  bcs_core #(
    .PULSE_HIGH_TICKS   (PULSE_HIGH_TICKS),
    .PULSE_PERIOD_TICKS (PULSE_PERIOD_TICKS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .command          (s1_cmd_r),
    .feedback_closed  (s1_fb_r),
    .inverter_running (s1_run_r),
    .cfg              (cfg),
    .preset           (preset),
    .res              (res)
  );

  assign out_valid         = out_v_r;
  assign out_breaker_state = out_r.state;
  assign out_on_coil       = out_r.on_coil;
  assign out_off_coil      = out_r.off_coil;
  assign out_uvr_coil      = out_r.uvr_coil;
  assign out_fault         = out_r.fault;
  assign out_event_code    = out_r.ev;

endmodule

// ===== tb/breaker_coil_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// breaker_coil_sequencer_test
// self-checking bench: a directed table of commands and ticks, then random
// mode sequences, not all legal, under several register settings, each result
// word compared field by field against a predictor kept in step with the block
// ----------------------------------------------------------------------------
module breaker_coil_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PulseHighTicks   = 600;
  localparam int PulsePeriodTicks = 1200;

  // command codes with no meaning to the block
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // one line of the directed table: a register write or an input word
  typedef struct {
    logic               is_cfg;
    bcs_pkg::reg_addr_t addr;
    logic [31:0]        value;
    logic [2:0]         cmd;
    logic               fb;
    logic               run;
    logic               typed;
    bcs_pkg::result_t   exp;
  } row_t;

  // one register setting for a random phase
  typedef struct {
    logic        breaker_type;
    logic        has_uvr;
    logic        has_feedback;
    logic [11:0] wait_ticks;
    logic [7:0]  on_pulse;
    logic [9:0]  fg_on;
    logic        start_on;
    int          words;
    int          tick_pct;
    logic        dwell_off;
  } setting_t;

  typedef enum logic [1:0] {
    SINK_STEADY, SINK_RANDOM, SINK_PERIODIC, SINK_SLOW
  } sink_style_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid            = 1'b0;
  logic       in_ready;
  logic [2:0] in_command          = bcs_pkg::CMD_TICK;
  logic       in_feedback_closed  = 1'b0;
  logic       in_inverter_running = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_breaker_state;
  logic       out_on_coil;
  logic       out_off_coil;
  logic       out_uvr_coil;
  logic       out_fault;
  logic [2:0] out_event_code;

  logic                      cfg_psel    = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite  = 1'b0;
  logic [bcs_pkg::AddrW-1:0] cfg_paddr   = '0;
  logic [bcs_pkg::DataW-1:0] cfg_pwdata  = '0;
  logic [bcs_pkg::DataW-1:0] cfg_prdata;
  logic                      cfg_pready;

  breaker_coil_sequencer #(
    .PULSE_HIGH_TICKS  (PulseHighTicks),
    .PULSE_PERIOD_TICKS(PulsePeriodTicks)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_feedback_closed (in_feedback_closed),
    .in_inverter_running(in_inverter_running),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_breaker_state  (out_breaker_state),
    .out_on_coil        (out_on_coil),
    .out_off_coil       (out_off_coil),
    .out_uvr_coil       (out_uvr_coil),
    .out_fault          (out_fault),
    .out_event_code     (out_event_code),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: register shadow plus the sequencer's own mode, timers
  // and coil drives, all at the block's widths
  // --------------------------------------------------------------------------
  bcs_pkg::cfg_t regs_shadow = '{breaker_type: 1'b0, has_uvr: 1'b0, has_feedback: 1'b1,
                                 reset_delay_ticks: 12'd1000, on_pulse_ticks: 8'd10,
                                 fg_on_ticks: 10'd120, start_on: 1'b0};

  bcs_pkg::mode_t               cur_mode    = bcs_pkg::MODE_RESET;
  logic [bcs_pkg::DelayW-1:0]   reset_wait  = '0;
  logic [bcs_pkg::OnPulseW-1:0] on_delay    = '0;
  logic [bcs_pkg::FgW-1:0]      fg_delay    = '0;
  logic [bcs_pkg::PulseW-1:0]   pulse_count = '0;
  logic                         coil_on     = 1'b0;
  logic                         coil_off    = 1'b0;
  logic                         coil_uvr    = 1'b0;
  // start_on presets the mode only until the first word goes through
  logic                         no_word_yet = 1'b1;

  bcs_pkg::result_t expected_q[$];
  int               bad_results = 0;

  // sender bookkeeping
  int   burst_left = 0;
  logic valid_held = 1'b0;

  // delay timers count up and stick at their limit
  function automatic int unsigned sat_inc(int unsigned cnt, int unsigned limit);
    return (cnt < limit) ? cnt + 1 : cnt;
  endfunction

  // commanded mode change: sets mode, timers and coils as needed and returns the event
  function automatic bcs_pkg::event_t enter_mode(bcs_pkg::mode_t target);
    logic shunt;
    shunt    = regs_shadow.breaker_type;
    fg_delay = '0;
    case (target)
      bcs_pkg::MODE_RESET: begin
        cur_mode   = bcs_pkg::MODE_RESET;
        reset_wait = '0;
        return bcs_pkg::EV_RESET;
      end
      bcs_pkg::MODE_OFF: begin
        cur_mode    = bcs_pkg::MODE_OFF;
        pulse_count = '0;
        coil_on     = 1'b0;
        coil_off    = !shunt;
        return bcs_pkg::EV_OFF;
      end
      bcs_pkg::MODE_ON: begin
        on_delay = '0;
        cur_mode = bcs_pkg::MODE_ON;
        coil_on  = shunt;
        coil_off = shunt;
        return bcs_pkg::EV_ON;
      end
      default: begin
        // no undervoltage release: a trip just opens the breaker
        if (!regs_shadow.has_uvr) begin
          cur_mode = bcs_pkg::MODE_OFF;
          coil_on  = 1'b0;
          coil_off = 1'b1;
          return bcs_pkg::EV_OFF;
        end
        cur_mode = bcs_pkg::MODE_TRIP;
        coil_uvr = shunt;
        coil_off = 1'b0;
        coil_on  = 1'b0;
        return bcs_pkg::EV_TRIP;
      end
    endcase
  endfunction

  // next result word for one accepted input word
  function automatic bcs_pkg::result_t step_sequencer(logic [2:0] cmd, logic fb, logic run);
    logic             closed;
    logic             shunt;
    bcs_pkg::result_t res;
    closed      = regs_shadow.has_feedback && fb;
    shunt       = regs_shadow.breaker_type;
    res.ev      = bcs_pkg::EV_NONE;
    res.fault   = 1'b0;
    no_word_yet = 1'b0;
    case (cmd)
      bcs_pkg::CMD_TICK: begin
        case (cur_mode)
          bcs_pkg::MODE_RESET: begin
            coil_on = 1'b0;
            if (!shunt) coil_off = 1'b1;
            if (regs_shadow.has_uvr) coil_uvr = !shunt;
            reset_wait = bcs_pkg::DelayW'(sat_inc(32'(reset_wait),
                                                  32'(regs_shadow.reset_delay_ticks)));
            if (reset_wait >= regs_shadow.reset_delay_ticks) begin
              // wait over: a closed contact holds the fault, open moves on
              if (closed) begin
                res.fault = 1'b1;
              end else begin
                cur_mode = bcs_pkg::MODE_OFF;
                coil_off = 1'b0;
                res.ev   = bcs_pkg::EV_OFF;
              end
            end
          end
          bcs_pkg::MODE_OFF: begin
            if (!closed && !shunt) begin
              if (!run) begin
                pulse_count = pulse_count + 1'b1;
                coil_off    = pulse_count < PulseHighTicks;
                if (pulse_count > PulsePeriodTicks) pulse_count = '0;
              end else begin
                coil_off = 1'b0;
              end
            end
          end
          bcs_pkg::MODE_ON: begin
            if (shunt) begin
              fg_delay = bcs_pkg::FgW'(sat_inc(32'(fg_delay), 32'(regs_shadow.fg_on_ticks)));
              if (fg_delay >= regs_shadow.fg_on_ticks) coil_off = 1'b0;
            end else begin
              on_delay = bcs_pkg::OnPulseW'(sat_inc(32'(on_delay),
                                                    32'(regs_shadow.on_pulse_ticks)));
              if (on_delay >= regs_shadow.on_pulse_ticks) begin
                coil_on  = 1'b1;
                coil_off = 1'b0;
              end
              if (closed) coil_on = 1'b0;
            end
          end
          default: ;
        endcase
      end
      bcs_pkg::CMD_RESET:
        if (cur_mode == bcs_pkg::MODE_TRIP) res.ev = enter_mode(bcs_pkg::MODE_RESET);
      bcs_pkg::CMD_OFF:
        if (cur_mode == bcs_pkg::MODE_ON) res.ev = enter_mode(bcs_pkg::MODE_OFF);
      bcs_pkg::CMD_ON:
        if (cur_mode == bcs_pkg::MODE_OFF) res.ev = enter_mode(bcs_pkg::MODE_ON);
      bcs_pkg::CMD_TRIP:
        if (cur_mode != bcs_pkg::MODE_TRIP) res.ev = enter_mode(bcs_pkg::MODE_TRIP);
      default: ;
    endcase
    res.state    = cur_mode;
    res.on_coil  = coil_on;
    res.off_coil = coil_off;
    res.uvr_coil = coil_uvr;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // result side: stall pattern and field-by-field check
  // --------------------------------------------------------------------------
  sink_style_t sink_style = SINK_STEADY;
  int          sink_left  = 0;
  int          sink_phase = 0;

  // the receiver switches between stall styles, each held for a random run length
  always @(posedge clk) begin : sink_pattern
    if (sink_left == 0) begin
      sink_style = sink_style_t'($urandom_range(0, 3));
      sink_left  = $urandom_range(20, 300);
    end
    sink_left--;
    sink_phase++;
    case (sink_style)
      SINK_STEADY:   out_ready <= 1'b1;
      SINK_RANDOM:   out_ready <= ($urandom_range(0, 2) != 0);
      SINK_PERIODIC: out_ready <= (sink_phase % 4 == 0);
      default:       out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void check_field(string field, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      bad_results++;
    end
  endfunction

  // every accepted result word is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    bcs_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result word with nothing expected, expected none, actual state %0d",
                 $time, out_breaker_state);
        bad_results++;
      end else begin
        want = expected_q.pop_front();
        check_field("breaker_state", 3'(want.state),    3'(out_breaker_state));
        check_field("on_coil",       3'(want.on_coil),  3'(out_on_coil));
        check_field("off_coil",      3'(want.off_coil), 3'(out_off_coil));
        check_field("uvr_coil",      3'(want.uvr_coil), 3'(out_uvr_coil));
        check_field("fault",         3'(want.fault),    3'(out_fault));
        check_field("event_code",    want.ev,           out_event_code);
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side and register port
  // --------------------------------------------------------------------------

  // drive one word; bursts of random length with random gaps between them
  task automatic send_word(input logic [2:0] cmd, input logic fb, input logic run);
    int gap;
    if (!valid_held) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_feedback_closed  <= fb;
    in_inverter_running <= run;
    valid_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  task automatic idle_input();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // setup cycle, access cycle, then an idle cycle before the next access
  task automatic write_reg(input bcs_pkg::reg_addr_t addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {addr, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      bcs_pkg::REG_BREAKER_TYPE: regs_shadow.breaker_type = value[0];
      bcs_pkg::REG_HAS_UVR:      regs_shadow.has_uvr      = value[0];
      bcs_pkg::REG_HAS_FEEDBACK: regs_shadow.has_feedback = value[0];
      bcs_pkg::REG_RESET_DELAY:
        regs_shadow.reset_delay_ticks = value[bcs_pkg::DelayW-1:0];
      bcs_pkg::REG_ON_PULSE:
        regs_shadow.on_pulse_ticks = value[bcs_pkg::OnPulseW-1:0];
      bcs_pkg::REG_FG_ON:
        regs_shadow.fg_on_ticks = value[bcs_pkg::FgW-1:0];
      bcs_pkg::REG_START_ON: begin
        regs_shadow.start_on = value[0];
        // before the first word start_on also loads the mode
        if (no_word_yet) cur_mode = value[0] ? bcs_pkg::MODE_ON : bcs_pkg::MODE_RESET;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    idle_input();
    wait_drained();
    write_reg(bcs_pkg::REG_BREAKER_TYPE, 32'(s.breaker_type));
    write_reg(bcs_pkg::REG_HAS_UVR,      32'(s.has_uvr));
    write_reg(bcs_pkg::REG_HAS_FEEDBACK, 32'(s.has_feedback));
    write_reg(bcs_pkg::REG_RESET_DELAY,  32'(s.wait_ticks));
    write_reg(bcs_pkg::REG_ON_PULSE,     32'(s.on_pulse));
    write_reg(bcs_pkg::REG_FG_ON,        32'(s.fg_on));
    write_reg(bcs_pkg::REG_START_ON,     32'(s.start_on));
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic row_t word_row(logic [2:0] cmd, logic fb, logic run);
    row_t row;
    row.is_cfg = 1'b0;
    row.addr   = bcs_pkg::REG_BREAKER_TYPE;
    row.value  = '0;
    row.cmd    = cmd;
    row.fb     = fb;
    row.run    = run;
    row.typed  = 1'b0;
    row.exp    = '0;
    return row;
  endfunction

  function automatic row_t cfg_row(bcs_pkg::reg_addr_t addr, logic [31:0] value);
    row_t row;
    row        = word_row(bcs_pkg::CMD_TICK, 1'b0, 1'b0);
    row.is_cfg = 1'b1;
    row.addr   = addr;
    row.value  = value;
    return row;
  endfunction

  function automatic row_t typed_row(logic [2:0] cmd, logic fb, logic run,
                                     bcs_pkg::mode_t st, logic on_c, logic off_c,
                                     logic uvr_c, logic flt, bcs_pkg::event_t ev);
    row_t row;
    row              = word_row(cmd, fb, run);
    row.typed        = 1'b1;
    row.exp.state    = st;
    row.exp.on_coil  = on_c;
    row.exp.off_coil = off_c;
    row.exp.uvr_coil = uvr_c;
    row.exp.fault    = flt;
    row.exp.ev       = ev;
    return row;
  endfunction

  function automatic setting_t make_setting(logic bt, logic uvr, logic fbk,
                                            logic [11:0] dly, logic [7:0] onp,
                                            logic [9:0] fg, logic st, int words,
                                            int tick_pct, logic dwell);
    setting_t s;
    s.breaker_type = bt;
    s.has_uvr      = uvr;
    s.has_feedback = fbk;
    s.wait_ticks   = dly;
    s.on_pulse     = onp;
    s.fg_on        = fg;
    s.start_on     = st;
    s.words        = words;
    s.tick_pct     = tick_pct;
    s.dwell_off    = dwell;
    return s;
  endfunction

  // a command that the current mode accepts, biased toward the on/off cycle
  function automatic logic [2:0] legal_cmd(bcs_pkg::mode_t m);
    case (m)
      bcs_pkg::MODE_OFF:
        return ($urandom_range(0, 3) != 0) ? bcs_pkg::CMD_ON : bcs_pkg::CMD_TRIP;
      bcs_pkg::MODE_ON:
        return ($urandom_range(0, 3) != 0) ? bcs_pkg::CMD_OFF : bcs_pkg::CMD_TRIP;
      bcs_pkg::MODE_TRIP: return bcs_pkg::CMD_RESET;
      default:            return bcs_pkg::CMD_TRIP;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t             plan[$];
    setting_t         phases[$];
    bcs_pkg::result_t pred;
    logic [2:0]       cmd;
    logic             fb;
    logic             run;
    int               pick;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; expectations typed in where they are plain to see,
    // the rest come from the predictor
    // preset into on mode with zero delays, undervoltage release fitted
    plan.push_back(cfg_row(bcs_pkg::REG_HAS_UVR, 32'd1));
    plan.push_back(cfg_row(bcs_pkg::REG_RESET_DELAY, 32'd0));
    plan.push_back(cfg_row(bcs_pkg::REG_ON_PULSE, 32'd0));
    plan.push_back(cfg_row(bcs_pkg::REG_START_ON, 32'd1));
    // zero on-delay closes the on coil at once, closed feedback drops it
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b0, 1'b0, bcs_pkg::MODE_ON,
                             1'b1, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b1, 1'b0, bcs_pkg::MODE_ON,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_OFF, 1'b1, 1'b1, bcs_pkg::MODE_OFF,
                             1'b0, 1'b1, 1'b0, 1'b0, bcs_pkg::EV_OFF));
    // illegal and unknown commands do nothing
    plan.push_back(typed_row(bcs_pkg::CMD_OFF, 1'b0, 1'b0, bcs_pkg::MODE_OFF,
                             1'b0, 1'b1, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_RESET, 1'b0, 1'b0, bcs_pkg::MODE_OFF,
                             1'b0, 1'b1, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(CMD_UNUSED_HI, 1'b1, 1'b1, bcs_pkg::MODE_OFF,
                             1'b0, 1'b1, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    // off-mode pulse, inverter running opens the off coil, closed holds it
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b0, 1'b0, bcs_pkg::MODE_OFF,
                             1'b0, 1'b1, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b0, 1'b1, bcs_pkg::MODE_OFF,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b1, 1'b0, bcs_pkg::MODE_OFF,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    // trip, repeated trip, reset back out of trip
    plan.push_back(typed_row(bcs_pkg::CMD_TRIP, 1'b0, 1'b0, bcs_pkg::MODE_TRIP,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_TRIP));
    plan.push_back(typed_row(bcs_pkg::CMD_TRIP, 1'b0, 1'b0, bcs_pkg::MODE_TRIP,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b1, 1'b1, bcs_pkg::MODE_TRIP,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_RESET, 1'b0, 1'b0, bcs_pkg::MODE_RESET,
                             1'b0, 1'b0, 1'b0, 1'b0, bcs_pkg::EV_RESET));
    // wait over with the breaker still closed: fault each tick until it opens
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b1, 1'b0, bcs_pkg::MODE_RESET,
                             1'b0, 1'b1, 1'b1, 1'b1, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b1, 1'b1, bcs_pkg::MODE_RESET,
                             1'b0, 1'b1, 1'b1, 1'b1, bcs_pkg::EV_NONE));
    plan.push_back(typed_row(bcs_pkg::CMD_TICK, 1'b0, 1'b0, bcs_pkg::MODE_OFF,
                             1'b0, 1'b0, 1'b1, 1'b0, bcs_pkg::EV_OFF));
    plan.push_back(typed_row(bcs_pkg::CMD_ON, 1'b0, 1'b0, bcs_pkg::MODE_ON,
                             1'b0, 1'b0, 1'b1, 1'b0, bcs_pkg::EV_ON));
    // shunt type, no feedback contact, no undervoltage release
    plan.push_back(cfg_row(bcs_pkg::REG_BREAKER_TYPE, 32'd1));
    plan.push_back(cfg_row(bcs_pkg::REG_HAS_FEEDBACK, 32'd0));
    plan.push_back(cfg_row(bcs_pkg::REG_FG_ON, 32'd0));
    plan.push_back(cfg_row(bcs_pkg::REG_HAS_UVR, 32'd0));
    plan.push_back(word_row(bcs_pkg::CMD_TICK, 1'b1, 1'b0));
    // trip without undervoltage release lands in off
    plan.push_back(typed_row(bcs_pkg::CMD_TRIP, 1'b0, 1'b0, bcs_pkg::MODE_OFF,
                             1'b0, 1'b1, 1'b1, 1'b0, bcs_pkg::EV_OFF));
    plan.push_back(word_row(bcs_pkg::CMD_ON, 1'b0, 1'b0));
    plan.push_back(word_row(bcs_pkg::CMD_TICK, 1'b1, 1'b1));
    plan.push_back(word_row(CMD_UNUSED_LO, 1'b0, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        idle_input();
        wait_drained();
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        send_word(plan[i].cmd, plan[i].fb, plan[i].run);
        pred = step_sequencer(plan[i].cmd, plan[i].fb, plan[i].run);
        expected_q.push_back(plan[i].typed ? plan[i].exp : pred);
      end
    end

    // random phases; the long off dwell walks the reset pulse through a full
    // period so the counter wraps, the extremes sit in the third phase
    phases.push_back(make_setting(1'b0, 1'b1, 1'b1, 12'd3,    8'd5,   10'd7,
                                  1'b0, 150, 75, 1'b0));
    phases.push_back(make_setting(1'b0, 1'b0, 1'b1, 12'd0,    8'd10,  10'd120,
                                  1'b0, 1300, 100, 1'b1));
    phases.push_back(make_setting(1'b1, 1'b1, 1'b0, 12'd4095, 8'd255, 10'd1023,
                                  1'b1, 150, 90, 1'b0));
    phases.push_back(make_setting(1'b0, 1'b1, 1'b1, 12'd20,   8'd40,  10'd60,
                                  1'b0, 150, 85, 1'b0));
    phases.push_back(make_setting(1'b1, 1'b0, 1'b1, 12'd1,    8'd0,   10'd2,
                                  1'b0, 150, 70, 1'b0));

    foreach (phases[p]) begin
      apply_setting(phases[p]);
      for (int k = 0; k < phases[p].words; k++) begin
        // hold the sender back until every result is in
        if (k == phases[p].words / 2) begin
          idle_input();
          wait_drained();
        end
        if (phases[p].dwell_off) begin
          // steer into off, then mostly idle ticks with the breaker open
          case (cur_mode)
            bcs_pkg::MODE_ON:   cmd = bcs_pkg::CMD_OFF;
            bcs_pkg::MODE_TRIP: cmd = bcs_pkg::CMD_RESET;
            default:            cmd = bcs_pkg::CMD_TICK;
          endcase
          fb  = ($urandom_range(0, 49) == 0);
          run = ($urandom_range(0, 49) == 0);
        end else begin
          pick = $urandom_range(0, 99);
          fb   = ($urandom_range(0, 2) == 0);
          run  = ($urandom_range(0, 3) == 0);
          if (pick < phases[p].tick_pct) cmd = bcs_pkg::CMD_TICK;
          else if (pick < phases[p].tick_pct + (100 - phases[p].tick_pct) * 3 / 4)
            cmd = legal_cmd(cur_mode);
          else cmd = 3'($urandom_range(0, 7));
        end
        send_word(cmd, fb, run);
        expected_q.push_back(step_sequencer(cmd, fb, run));
      end
    end

    // let the last results out, then watch a little longer for strays
    idle_input();
    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
